### rtl/mrs_pkg.sv
// shared constants and types for the matrix row sort block
package mrs_pkg;

    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef struct packed {
        logic push;
        logic pass_start;
        logic compare;
        logic advance;
    } t_sort_ctl;

endpackage

### rtl/mrs_store.sv
// element memory with one write port and one registered read port
module mrs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mrs_pkg::VALUE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [mrs_pkg::VALUE_W-1:0] o_rdata
);

    logic [mrs_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [mrs_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mrs_sort.sv
// row total sequence with one shared compare unit for bubble passes
module mrs_sort #(
    parameter int MAX_SIZE = 8,
    parameter int SUM_W    = 35,
    parameter int RW       = 3,
    parameter int CW       = 4
) (
    input  logic                    i_clk,
    input  mrs_pkg::t_sort_ctl      i_ctl,
    input  logic [CW-1:0]           i_n,
    input  logic signed [SUM_W-1:0] i_new_total,
    input  logic [RW-1:0]           i_new_idx,
    input  logic                    i_last_row,
    output logic [RW-1:0]           o_src_idx
);

    logic signed [SUM_W-1:0] r_tot [MAX_SIZE];
    logic [RW-1:0]           r_idx [MAX_SIZE];
    logic signed [SUM_W-1:0] r_ctot;
    logic [RW-1:0]           r_cidx;

    logic signed [SUM_W-1:0] w_sh_tot [MAX_SIZE];
    logic [RW-1:0]           w_sh_idx [MAX_SIZE];
    logic                    w_gt;
    logic signed [SUM_W-1:0] w_ins_tot;
    logic [RW-1:0]           w_ins_idx;
    logic signed [SUM_W-1:0] n_ctot;
    logic [RW-1:0]           n_cidx;
    logic                    w_move;
    logic                    w_insert;

    always_comb begin
        for (int k = 0; k < MAX_SIZE - 1; k++) begin
            w_sh_tot[k] = r_tot[k+1];
            w_sh_idx[k] = r_idx[k+1];
        end
        w_sh_tot[MAX_SIZE-1] = r_tot[MAX_SIZE-1];
        w_sh_idx[MAX_SIZE-1] = r_idx[MAX_SIZE-1];
    end

    // carried entry moves on only when strictly greater, which keeps ties in order
    assign w_gt = r_ctot > r_tot[0];

    always_comb begin
        w_ins_tot = r_ctot;
        w_ins_idx = r_cidx;
        n_ctot    = r_ctot;
        n_cidx    = r_cidx;
        if (i_ctl.push) begin
            n_ctot = i_new_total;
            n_cidx = i_new_idx;
        end else if (i_ctl.pass_start) begin
            n_ctot = r_tot[0];
            n_cidx = r_idx[0];
        end else if (i_ctl.compare) begin
            if (w_gt) begin
                w_ins_tot = r_tot[0];
                w_ins_idx = r_idx[0];
            end else begin
                n_ctot = r_tot[0];
                n_cidx = r_idx[0];
            end
        end
    end

    assign w_insert = i_ctl.push | i_ctl.pass_start | i_ctl.compare;
    assign w_move   = w_insert | i_ctl.advance;

    always_ff @(posedge i_clk) begin
        r_ctot <= n_ctot;
        r_cidx <= n_cidx;
        if (w_move) begin
            for (int k = 0; k < MAX_SIZE; k++) begin
                if (w_insert && (k + 2 == int'(i_n))) begin
                    r_tot[k] <= w_ins_tot;
                    r_idx[k] <= w_ins_idx;
                end else begin
                    r_tot[k] <= w_sh_tot[k];
                    r_idx[k] <= w_sh_idx[k];
                end
            end
        end
    end

    assign o_src_idx = i_last_row ? r_cidx : r_idx[0];

endmodule

### rtl/matrix_row_sort_by_sum_top.sv
// top level of the matrix row sort by row sum block
// usage:
//   write the matrix size on i_cfg_we/i_cfg_data while the block is idle;
//   zero counts as one and sizes above MAX_SIZE saturate; a write drops
//   any partially loaded matrix. reset leaves the size at eight.
//   input words are matrix elements in row-major order, one per cycle
//   while o_in_ready is high; a running row total is kept exactly.
//   after the last element the block runs n-1 bubble passes through
//   one shared compare unit, so rows come out stably ordered
//   by ascending total; o_in_ready is low meanwhile.
//   it then reads the element memory one word per cycle unless the
//   receiver stalls, and emits the n*n words row by row, with
//   o_last_of_matrix on the final one. the output words come
//   straight from the registered memory read.
//   a stalled receiver holds the output register and halts the reads;
//   the next matrix may load while the final word still waits.
//   reset returns the block to loading with an empty matrix.
module matrix_row_sort_by_sum_top #(
    parameter int MAX_SIZE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mrs_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mrs_pkg::VALUE_W-1:0] i_element_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mrs_pkg::VALUE_W-1:0] o_out_value,
    output logic                              o_last_of_matrix
);

    localparam int RW    = $clog2(MAX_SIZE);
    localparam int CW    = $clog2(MAX_SIZE + 1);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = mrs_pkg::VALUE_W + $clog2(MAX_SIZE);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_SIZE);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [mrs_pkg::SIZE_W-1:0] r_size;
    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_col, n_col;
    logic [RW-1:0] r_pass, n_pass;
    logic [RW-1:0] r_step, n_step;
    logic signed [SUM_W-1:0] r_acc;
    logic r_ov, n_ov;
    logic r_last, n_last;

    logic [CW-1:0] w_n;
    logic w_accept;
    logic w_row_last;
    logic w_col_last;
    logic w_step_last;
    logic w_pass_last;
    logic w_issue;
    logic w_word_last;
    logic signed [SUM_W-1:0] w_sum;
    logic [AW-1:0] w_addr;
    logic [RW-1:0] w_src;
    mrs_pkg::t_sort_ctl w_ctl;

    always_comb begin
        if (r_size == '0) begin
            w_n = CW'(1);
        end else if (int'(r_size) > MAX_SIZE) begin
            w_n = CW'(MAX_SIZE);
        end else begin
            w_n = CW'(r_size);
        end
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_row_last  = (CW'(r_row) + CW'(1) == w_n);
    assign w_col_last  = (CW'(r_col) + CW'(1) == w_n);
    assign w_step_last = (CW'(r_step) + CW'(1) == w_n);
    assign w_pass_last = (CW'(r_pass) + CW'(2) == w_n);
    assign w_issue     = (r_state == ST_EMIT) & (~r_ov | i_out_ready);
    assign w_word_last = w_row_last & w_col_last;

    assign w_sum = ((r_col == '0) ? SUM_W'(0) : r_acc)
                   + SUM_W'(i_element_value);
    assign w_addr = AW'(r_row) * ROW_STRIDE + AW'(r_col);

    always_comb begin
        w_ctl            = '0;
        w_ctl.push       = w_accept & w_col_last;
        w_ctl.pass_start = (r_state == ST_SORT) & (r_step == '0);
        w_ctl.compare    = (r_state == ST_SORT) & (r_step != '0);
        w_ctl.advance    = w_issue & w_col_last;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_pass  = r_pass;
        n_step  = r_step;
        n_ov    = r_ov;
        n_last  = r_last;
        if (i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_col_last) begin
                        n_col = '0;
                        if (w_row_last) begin
                            n_row  = '0;
                            n_pass = '0;
                            n_step = '0;
                            n_state = (w_n == CW'(1)) ? ST_EMIT : ST_SORT;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_col = r_col + RW'(1);
                    end
                end
            end
            ST_SORT: begin
                if (w_step_last) begin
                    n_step = '0;
                    n_pass = r_pass + RW'(1);
                    if (w_pass_last) begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_step = r_step + RW'(1);
                end
            end
            ST_EMIT: begin
                if (w_issue) begin
                    n_ov   = 1'b1;
                    n_last = w_word_last;
                    if (w_col_last) begin
                        n_col = '0;
                        if (w_row_last) begin
                            n_row   = '0;
                            n_state = ST_LOAD;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_col = r_col + RW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        if (i_cfg_we) begin
            n_state = ST_LOAD;
            n_row   = '0;
            n_col   = '0;
            n_pass  = '0;
            n_step  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_size  <= mrs_pkg::SIZE_RESET;
            r_row   <= '0;
            r_col   <= '0;
            r_pass  <= '0;
            r_step  <= '0;
            r_ov    <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pass  <= n_pass;
            r_step  <= n_step;
            r_ov    <= n_ov;
            r_last  <= n_last;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc <= w_sum;
        end
    end

    mrs_sort #(
        .MAX_SIZE (MAX_SIZE),
        .SUM_W    (SUM_W),
        .RW       (RW),
        .CW       (CW)
    ) u_sort (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_n         (w_n),
        .i_new_total (w_sum),
        .i_new_idx   (r_row),
        .i_last_row  (w_row_last),
        .o_src_idx   (w_src)
    );

    mrs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_addr),
        .i_wdata (i_element_value),
        .i_re    (w_issue),
        .i_raddr (AW'(w_src) * ROW_STRIDE + AW'(r_col)),
        .o_rdata (o_out_value)
    );

    assign o_out_valid      = r_ov;
    assign o_last_of_matrix = r_last;

    a_issue_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> o_out_valid)
        else $error("issued read did not produce an output word");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_word_last && !i_cfg_we) |=> (r_state == ST_LOAD))
        else $error("emission continued past the final word");

    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT) |-> (CW'(r_pass) + CW'(1) < w_n))
        else $error("sort pass count out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (CW'(r_row) < w_n && CW'(r_col) < w_n))
        else $error("load position outside matrix");

    a_no_load_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !w_accept)
        else $error("element taken while sorting or emitting");

endmodule
